[design/pfp_pkg.sv]
`timescale 1ns / 1ps
// Package for the pub/sub frame parser: byte codes, parser state, result
// types and the per-byte step functions. No dependencies.
package pfp_pkg;

	localparam logic [7:0] BYTE_CR = 8'd13;
	localparam logic [7:0] BYTE_LF = 8'd10;
	localparam logic [7:0] BYTE_SP = 8'd32;

	localparam logic [2:0] PUB_LEN    = 3'd3;
	localparam logic [2:0] MATCH_FAIL = 3'd4;

	// Result queue geometry.
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_CMD,
		PH_TOPIC,
		PH_CONTENT,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		KIND_CMD     = 3'd0,
		KIND_TOPIC   = 3'd1,
		KIND_CONTENT = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_ERR     = 3'd4
	} kind_t;

	typedef struct packed {
		phase_t     phase;
		logic       cr_pending;
		logic [2:0] cmd_match;
		logic       cmd_nonempty;
		logic       topic_nonempty;
		logic       header_bad;
	} pfp_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       is_pub;
		logic       last;
	} res_t;

	// Outcome of handling one byte or one line end.
	typedef struct packed {
		pfp_state_t st;
		logic       v;
		kind_t      kind;
		logic [7:0] data;
		logic       pub;
	} step_t;

	// Results written into the result queue at the same time.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic             room2;
		logic [RQ_CW-1:0] count;
	} rq_stat_t;

	function automatic pfp_state_t st_clear();
		pfp_state_t s;
		s = '0;
		s.phase = PH_CMD;
		return s;
	endfunction

	function automatic logic [7:0] pub_char(logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h70;
			2'd1: c = 8'h75;
			default: c = 8'h62;
		endcase
		return c;
	endfunction

	// One data byte in the current field.
	function automatic step_t put_data(pfp_state_t st, logic [7:0] b);
		step_t r;
		r      = '0;
		r.st   = st;
		r.kind = KIND_CMD;
		r.data = b;
		case (st.phase)
			PH_CMD: begin
				if (b == BYTE_SP) begin
					r.st.header_bad = !st.cmd_nonempty;
					r.st.phase      = PH_TOPIC;
				end else begin
					r.v               = 1'b1;
					r.kind            = KIND_CMD;
					r.st.cmd_nonempty = 1'b1;
					if (st.cmd_match < PUB_LEN && b == pub_char(st.cmd_match[1:0]))
						r.st.cmd_match = st.cmd_match + 3'd1;
					else
						r.st.cmd_match = MATCH_FAIL;
				end
			end
			PH_TOPIC: begin
				r.v                 = 1'b1;
				r.kind              = KIND_TOPIC;
				r.st.topic_nonempty = 1'b1;
			end
			PH_CONTENT: begin
				r.v    = 1'b1;
				r.kind = KIND_CONTENT;
			end
			default: begin
				r.v = 1'b0;
			end
		endcase
		return r;
	endfunction

	// A CR LF pair closes the current line.
	function automatic step_t end_line(pfp_state_t st);
		step_t r;
		r    = '0;
		r.st = st;
		if (st.phase == PH_CONTENT) begin
			r.v    = 1'b1;
			r.kind = KIND_DONE;
			r.pub  = 1'b1;
			r.st   = st_clear();
		end else if (st.phase == PH_CMD || st.header_bad || !st.topic_nonempty ||
				!st.cmd_nonempty) begin
			r.v             = 1'b1;
			r.kind          = KIND_ERR;
			r.st.phase      = PH_ERROR;
			r.st.cr_pending = 1'b0;
		end else if (st.cmd_match == PUB_LEN) begin
			r.kind     = KIND_DONE;
			r.st.phase = PH_CONTENT;
		end else begin
			r.v    = 1'b1;
			r.kind = KIND_DONE;
			r.st   = st_clear();
		end
		return r;
	endfunction

endpackage

[design/pfp_if.sv]
`timescale 1ns / 1ps
// Handshake channels of the pub/sub frame parser: raw byte input and
// tagged result output. No dependencies.
interface pfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface pfp_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] out_byte;
	logic       is_pub;
	logic       last;

	modport source (output valid, output kind, output out_byte, output is_pub,
		output last, input ready);
	modport sink (input valid, input kind, input out_byte, input is_pub,
		input last, output ready);
endinterface

[design/pubsub_frame_parser.sv]
`timescale 1ns / 1ps
// Top level of the pub/sub frame parser: input register, decode core and
// result queue. Depends on pfp_pkg, pfp_if, pfp_core and pfp_rq.
//
//   channel | dir | payload                          | per transfer
//   rx      | in  | data_byte[7:0]                   | one raw stream byte
//   res     | out | kind[2:0] out_byte[7:0] is_pub last | one tagged result
//
// Each byte is registered on transfer, decoded from that register by the
// core's short combinational path and written, with up to two results,
// into a four-entry result queue. A new byte is taken in every cycle as
// long as the queue has room for two results, so bytes that give one
// result run at full rate and the queue only throttles when bytes release
// a held CR alongside a data byte or when the consumer stalls.
// Reset clears the parser state, the input stage and the queue; the
// error phase is left only through reset.
module pubsub_frame_parser
	import pfp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	pfp_byte_if.sink rx,
	pfp_res_if.source res
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	push_t      push;
	pfp_state_t state;
	rq_stat_t   stat;
	logic       rq_valid;
	res_t       head;

	// The registered byte moves on only when the queue can take two results.
	assign adv      = valid_s1 && stat.room2;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.data_byte;
	end

	pfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.data_byte (byte_s1),
		.push      (push),
		.state     (state)
	);

	pfp_rq u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (res.ready),
		.valid  (rq_valid),
		.head   (head),
		.stat   (stat)
	);

	assign res.valid    = rq_valid;
	assign res.kind     = head.kind;
	assign res.out_byte = head.out_byte;
	assign res.is_pub   = head.is_pub;
	assign res.last     = head.last;

	// The error phase is sticky.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state.phase == PH_ERROR |=> state.phase == PH_ERROR)
		else $error("error phase left without reset");

	// Nothing is produced while in the error phase.
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state.phase == PH_ERROR |-> push.n == 2'd0)
		else $error("result produced in error phase");

	// The queue never overflows.
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= RQ_CW'(RQ_DEPTH))
		else $error("result queue overflow");

	// The pub flag only rides on a frame-complete result.
	a_pub_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.kind != KIND_DONE) |-> !res.is_pub)
		else $error("pub flag on a non-complete result");

endmodule

[design/pfp_core.sv]
`timescale 1ns / 1ps
// Parser state and per-byte decode: turns one registered byte into up to two
// results. Depends on pfp_pkg.
module pfp_core
	import pfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	output push_t      push,
	output pfp_state_t state
);

	pfp_state_t st_q;
	pfp_state_t st_d;
	step_t      a;
	step_t      b;
	pfp_state_t s0;
	step_t      first;

	always_comb begin
		s0   = st_q;
		a    = '0;
		b    = '0;
		st_d = st_q;
		if (st_q.phase == PH_ERROR) begin
			st_d = st_q;
		end else if (st_q.cr_pending) begin
			if (data_byte == BYTE_LF) begin
				s0.cr_pending = 1'b0;
				a             = end_line(s0);
				st_d          = a.st;
			end else if (data_byte == BYTE_CR) begin
				// First CR goes out as data, the new one stays held.
				a    = put_data(s0, BYTE_CR);
				st_d = a.st;
			end else begin
				s0.cr_pending = 1'b0;
				a             = put_data(s0, BYTE_CR);
				b             = put_data(a.st, data_byte);
				st_d          = b.st;
			end
		end else if (data_byte == BYTE_CR) begin
			st_d.cr_pending = 1'b1;
		end else begin
			a    = put_data(st_q, data_byte);
			st_d = a.st;
		end
	end

	always_comb begin
		first         = a.v ? a : b;
		push.n        = {1'b0, a.v} + {1'b0, b.v};
		push.r0.kind     = first.kind;
		push.r0.out_byte = (first.kind == KIND_DONE || first.kind == KIND_ERR) ?
			8'd0 : first.data;
		push.r0.is_pub   = first.pub;
		push.r0.last     = !(a.v && b.v);
		push.r1.kind     = b.kind;
		push.r1.out_byte = (b.kind == KIND_DONE || b.kind == KIND_ERR) ? 8'd0 : b.data;
		push.r1.is_pub   = b.pub;
		push.r1.last     = 1'b1;
		if (!step)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_clear();
		end else if (step) begin
			st_q <= st_d;
		end
	end

	assign state = st_q;

endmodule

[design/pfp_rq.sv]
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per
// transfer. Depends on pfp_pkg.
module pfp_rq
	import pfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  push_t    push,
	input  logic     pop,
	output logic     valid,
	output res_t     head,
	output rq_stat_t stat
);

	res_t             mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0] wp_q;
	logic [RQ_AW-1:0] rp_q;
	logic [RQ_CW-1:0] count_q;
	logic             do_pop;

	assign valid  = (count_q != '0);
	assign do_pop = pop && valid;
	assign head   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + RQ_AW'(push.n);
			rp_q    <= rp_q + RQ_AW'(do_pop);
			count_q <= count_q + RQ_CW'(push.n) - RQ_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wp_q + RQ_AW'(1)] <= push.r1;
	end

	assign stat.room2 = (count_q <= RQ_CW'(RQ_DEPTH - 2));
	assign stat.count = count_q;

endmodule
